>>> src/bga_pkg.sv
// Shared types, constants and helper functions for the bi-allelic genotype likelihood block.
package bga_pkg;

  localparam int unsigned MaxAlleles = 64;

  localparam logic [5:0] RefIndex      = 6'd0;
  localparam logic [5:0] FirstAltIndex = 6'd1;

  localparam int unsigned LikeW = 21;
  localparam logic [LikeW-1:0] WeightHigh = 21'd24;
  localparam logic [LikeW-1:0] WeightMid  = 21'd12;
  localparam logic [LikeW-1:0] WeightLow  = 21'd3;
  localparam logic [7:0]       PhredMax   = 8'hFF;

  typedef struct packed {
    logic [7:0] hom_ref;
    logic [7:0] het;
    logic [7:0] hom_alt;
  } phred_t;

  typedef struct packed {
    logic [5:0]  allele_index;
    logic [15:0] allele_depth;
    logic        last_allele;
    logic [7:0]  amb_depth;
    logic [15:0] ref_total;
    logic [15:0] alt_total;
    logic [7:0]  proper_pair;
    logic [5:0]  target_alt;
    phred_t      phred;
  } item_t;

  typedef struct packed {
    logic [15:0] ref_uniq;
    logic [15:0] second_depth;
    logic [7:0]  amb;
    logic [7:0]  amb_new;
    logic [15:0] ref_total;
    logic [15:0] alt_total;
    logic [7:0]  proper_pair;
    logic [5:0]  target;
    logic [15:0] acc;
  } state_t;

  typedef struct packed {
    logic   pass;
    phred_t phred;
  } tok_t;

  typedef struct packed {
    logic        pass;
    phred_t      phred;
    logic [15:0] cov0;
    logic [15:0] cov1;
    logic [7:0]  amb;
    logic [15:0] ref_total;
    logic [15:0] alt_total;
    logic [7:0]  pp;
  } red_t;

  typedef struct packed {
    red_t             red;
    logic [LikeW-1:0] g00;
    logic [LikeW-1:0] g01;
    logic [LikeW-1:0] g11;
  } wgt_t;

  typedef struct packed {
    logic adv2;
    logic adv3;
    logic adv4;
    logic adv5;
  } pipe_t;

  function automatic logic [15:0] floor_sub16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : 16'd0;
  endfunction

  function automatic logic [7:0] floor_sub_pp(input logic [7:0] a, input logic [15:0] b);
    return ({8'd0, a} > b) ? (a - b[7:0]) : 8'd0;
  endfunction

endpackage

>>> src/bga_accum.sv
// Per-call state registers, updated by allele words, and the end-of-call token stage.
module bga_accum import bga_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  pipe_t  pipe,
  input  logic   s1_valid,
  input  item_t  s1_item,
  output state_t state,
  output logic   s2_valid,
  output tok_t   s2_tok
);

  state_t      state_r, state_nxt;
  logic        s2_valid_r;
  tok_t        tok_r;
  logic        in_range;
  logic        target_hit;
  logic [15:0] ref_gap;

  always_comb begin
    state_nxt  = state_r;
    in_range   = 32'(s1_item.allele_index) < MaxAlleles;
    target_hit = {1'b0, s1_item.allele_index} == ({1'b0, state_r.target} + 7'd1);
    ref_gap    = s1_item.ref_total - s1_item.allele_depth;
    if (s1_valid && in_range) begin
      if (s1_item.allele_index == RefIndex) begin
        state_nxt.ref_uniq     = s1_item.allele_depth;
        state_nxt.second_depth = 16'd0;
        state_nxt.amb          = s1_item.amb_depth;
        // The recomputed ambiguous depth reduces to the reference shortfall.
        state_nxt.amb_new      = (s1_item.ref_total > s1_item.allele_depth) ?
                                 ref_gap[7:0] : 8'd0;
        state_nxt.ref_total    = s1_item.ref_total;
        state_nxt.alt_total    = s1_item.alt_total;
        state_nxt.proper_pair  = s1_item.proper_pair;
        state_nxt.target       = s1_item.target_alt;
        state_nxt.acc          = s1_item.alt_total;
      end else if (s1_item.allele_index == FirstAltIndex) begin
        state_nxt.second_depth = s1_item.allele_depth;
      end else if (!target_hit) begin
        // Only the positive part of the target depth survives, so flooring at zero
        // here gives the same final depth.
        state_nxt.acc         = floor_sub16(state_r.acc, s1_item.allele_depth);
        state_nxt.alt_total   = floor_sub16(state_r.alt_total, s1_item.allele_depth);
        state_nxt.proper_pair = floor_sub_pp(state_r.proper_pair, s1_item.allele_depth);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= '0;
      s2_valid_r <= 1'b0;
    end else if (pipe.adv2) begin
      state_r    <= state_nxt;
      s2_valid_r <= s1_valid && s1_item.last_allele;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv2) begin
      tok_r.pass  <= s1_item.allele_index == FirstAltIndex;
      tok_r.phred <= s1_item.phred;
    end
  end

  assign state    = state_r;
  assign s2_valid = s2_valid_r;
  assign s2_tok   = tok_r;

endmodule

>>> src/bga_reduce.sv
// Final depth reduction of a finished call, registered for the likelihood stages.
module bga_reduce import bga_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  pipe_t  pipe,
  input  logic   s2_valid,
  input  state_t state,
  input  tok_t   s2_tok,
  output logic   s3_valid,
  output red_t   s3
);

  logic        s3_valid_r;
  red_t        red_r, red_nxt;
  logic [15:0] sub;
  logic [16:0] need;
  logic [15:0] cov1;

  always_comb begin
    sub  = (state.target != 6'd0) ? state.second_depth : 16'd0;
    need = {1'b0, sub} + {9'd0, state.amb_new};
    cov1 = ({1'b0, state.acc} > need) ? (state.acc - need[15:0]) : 16'd0;

    red_nxt.pass      = s2_tok.pass;
    red_nxt.phred     = s2_tok.phred;
    red_nxt.cov0      = state.ref_uniq;
    red_nxt.ref_total = state.ref_total;
    if (s2_tok.pass) begin
      red_nxt.cov1      = state.second_depth;
      red_nxt.amb       = state.amb;
      red_nxt.alt_total = state.alt_total;
      red_nxt.pp        = state.proper_pair;
    end else begin
      red_nxt.cov1      = cov1;
      red_nxt.amb       = state.amb_new;
      red_nxt.alt_total = floor_sub16(state.alt_total, sub);
      red_nxt.pp        = floor_sub_pp(state.proper_pair, sub);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (pipe.adv3) begin
      s3_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv3) begin
      red_r <= red_nxt;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3       = red_r;

endmodule

>>> src/bga_like.sv
// Weighted likelihood stage and min-normalizing, saturating result register.
module bga_like import bga_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t pipe,
  input  logic  s3_valid,
  input  red_t  s3,
  output logic  s4_valid,
  output logic  res_valid,
  output red_t  res
);

  logic             s4_valid_r, res_valid_r;
  wgt_t             wgt_r, wgt_nxt;
  red_t             res_r, res_nxt;
  logic [15:0]      proper;
  logic [LikeW-1:0] mn;
  logic [LikeW-1:0] d00, d01, d11;

  function automatic logic [7:0] sat8(input logic [LikeW-1:0] v);
    return (v > LikeW'(PhredMax)) ? PhredMax : v[7:0];
  endfunction

  always_comb begin
    proper      = (s3.cov1 < {8'd0, s3.pp}) ? s3.cov1 : {8'd0, s3.pp};
    wgt_nxt.red = s3;
    // 24 per proper read plus 12 per non-proper read is 12 * (cov1 + proper).
    wgt_nxt.g00 = (LikeW'(s3.cov1) + LikeW'(proper)) * WeightMid;
    wgt_nxt.g01 = (LikeW'(s3.cov0) + LikeW'(s3.cov1)) * WeightLow;
    wgt_nxt.g11 = LikeW'(s3.cov0) * WeightHigh;
  end

  always_comb begin
    mn = wgt_r.g00;
    if (wgt_r.g01 < mn) begin
      mn = wgt_r.g01;
    end
    if (wgt_r.g11 < mn) begin
      mn = wgt_r.g11;
    end
    d00     = wgt_r.g00 - mn;
    d01     = wgt_r.g01 - mn;
    d11     = wgt_r.g11 - mn;
    res_nxt = wgt_r.red;
    if (!wgt_r.red.pass) begin
      res_nxt.phred.hom_ref = sat8(d00);
      res_nxt.phred.het     = sat8(d01);
      res_nxt.phred.hom_alt = sat8(d11);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (pipe.adv4) begin
        s4_valid_r <= s3_valid;
      end
      if (pipe.adv5) begin
        res_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv4) begin
      wgt_r <= wgt_nxt;
    end
    if (pipe.adv5) begin
      res_r <= res_nxt;
    end
  end

  assign s4_valid  = s4_valid_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> src/biallelic_genotype_likelihoods.sv
// Top level: bi-allelic reduction of a multi-allelic genotype call with likelihood recompute.
// The result word of a call reaches the output register after the word that ends the call is
// accepted and has passed through five register levels.
// Throughput: one input word per cycle while in_stall is low; a call of N alleles is N input words.
// Reset: rst_n is synchronous and active low; it empties the pipeline and clears the
// per-call depth state to zero.
module biallelic_genotype_likelihoods import bga_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_allele_index,
  input  logic [15:0] in_allele_depth,
  input  logic        in_last_allele,
  input  logic [7:0]  in_amb_depth_in,
  input  logic [15:0] in_ref_total_in,
  input  logic [15:0] in_alt_total_in,
  input  logic [7:0]  in_proper_pair_in,
  input  logic [5:0]  in_target_alt,
  input  logic [7:0]  in_orig_hom_ref_phred,
  input  logic [7:0]  in_orig_het_phred,
  input  logic [7:0]  in_orig_hom_alt_phred,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_hom_ref_phred,
  output logic [7:0]  out_het_phred,
  output logic [7:0]  out_hom_alt_phred,
  output logic [15:0] out_ref_depth_out,
  output logic [15:0] out_alt_depth_out,
  output logic [7:0]  out_amb_depth_out,
  output logic [15:0] out_ref_total_out,
  output logic [15:0] out_alt_total_out,
  output logic [7:0]  out_proper_pair_out
);

  // The pipeline has five register levels:
  //   stage 1  input register holding the accepted word;
  //   stage 2  per-call state registers plus an end-of-call token (bga_accum);
  //   stage 3  reduced depths of a finished call (bga_reduce);
  //   stage 4  the three weighted likelihoods (bga_like);
  //   stage 5  min-normalized, saturated result register (bga_like).
  // Each stage loads whenever it is empty or its contents move on, so bubbles close up and
  // a word is accepted every cycle unless the output register holds a stalled result and
  // every stage behind it is full.

  logic   s1_valid_r;
  item_t  s1_item_r, s1_item_nxt;
  logic   adv1;
  pipe_t  pipe;
  state_t state;
  logic   s2_valid, s3_valid, s4_valid, res_valid;
  tok_t   s2_tok;
  red_t   s3, res;

  // Stall chain from the output back to the input.
  always_comb begin
    pipe.adv5 = !res_valid || !out_stall;
    pipe.adv4 = !s4_valid || pipe.adv5;
    pipe.adv3 = !s3_valid || pipe.adv4;
    pipe.adv2 = !s2_valid || pipe.adv3;
    adv1      = !s1_valid_r || pipe.adv2;
  end

  assign in_stall = !adv1;

  always_comb begin
    s1_item_nxt.allele_index  = in_allele_index;
    s1_item_nxt.allele_depth  = in_allele_depth;
    s1_item_nxt.last_allele   = in_last_allele;
    s1_item_nxt.amb_depth     = in_amb_depth_in;
    s1_item_nxt.ref_total     = in_ref_total_in;
    s1_item_nxt.alt_total     = in_alt_total_in;
    s1_item_nxt.proper_pair   = in_proper_pair_in;
    s1_item_nxt.target_alt    = in_target_alt;
    s1_item_nxt.phred.hom_ref = in_orig_hom_ref_phred;
    s1_item_nxt.phred.het     = in_orig_het_phred;
    s1_item_nxt.phred.hom_alt = in_orig_hom_alt_phred;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  // Every word except one at index target+1, when that index exceeds 1, updates the call state as it
  // leaves stage 1; only a word that ends the call carries a token on toward the output.
  bga_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .pipe     (pipe),
    .s1_valid (s1_valid_r),
    .s1_item  (s1_item_r),
    .state    (state),
    .s2_valid (s2_valid),
    .s2_tok   (s2_tok)
  );

  // The state is read while the token waits in stage 2; a following word can only
  // overwrite it at the same edge that stage 3 captures the reduced depths.
  bga_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .pipe     (pipe),
    .s2_valid (s2_valid),
    .state    (state),
    .s2_tok   (s2_tok),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  // A two-allele call keeps its original phreds; otherwise the weighted likelihoods are
  // normalized to their minimum and clipped at 255.
  bga_like u_like (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe      (pipe),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .s4_valid  (s4_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid           = res_valid;
  assign out_hom_ref_phred   = res.phred.hom_ref;
  assign out_het_phred       = res.phred.het;
  assign out_hom_alt_phred   = res.phred.hom_alt;
  assign out_ref_depth_out   = res.cov0;
  assign out_alt_depth_out   = res.cov1;
  assign out_amb_depth_out   = res.amb;
  assign out_ref_total_out   = res.ref_total;
  assign out_alt_total_out   = res.alt_total;
  assign out_proper_pair_out = res.pp;

endmodule

>>> src/bga_chk.sv
// Port-level checker for the bi-allelic genotype likelihood block and its bind.
module bga_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [5:0]  in_allele_index,
  input logic [15:0] in_allele_depth,
  input logic        in_last_allele,
  input logic [7:0]  in_amb_depth_in,
  input logic [15:0] in_ref_total_in,
  input logic [15:0] in_alt_total_in,
  input logic [7:0]  in_proper_pair_in,
  input logic [5:0]  in_target_alt,
  input logic [7:0]  in_orig_hom_ref_phred,
  input logic [7:0]  in_orig_het_phred,
  input logic [7:0]  in_orig_hom_alt_phred,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_hom_ref_phred,
  input logic [7:0]  out_het_phred,
  input logic [7:0]  out_hom_alt_phred,
  input logic [15:0] out_ref_depth_out,
  input logic [15:0] out_alt_depth_out,
  input logic [7:0]  out_amb_depth_out,
  input logic [15:0] out_ref_total_out,
  input logic [15:0] out_alt_total_out,
  input logic [7:0]  out_proper_pair_out
);

  // Calls whose final word was accepted but whose result word has not yet been taken.
  logic [2:0] pend_r, pend_nxt;
  logic       call_in, call_out;

  assign call_in  = in_valid && !in_stall && in_last_allele;
  assign call_out = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r + {2'd0, call_in} - {2'd0, call_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hom_ref_phred) &&
      $stable(out_het_phred) && $stable(out_hom_alt_phred) &&
      $stable(out_ref_depth_out) && $stable(out_alt_depth_out) &&
      $stable(out_amb_depth_out) && $stable(out_ref_total_out) &&
      $stable(out_alt_total_out) && $stable(out_proper_pair_out))
    else $error("result word changed while stalled");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled while the output side is free");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result word without a finished call");

  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd5)
    else $error("more calls in flight than pipeline stages");

endmodule

bind biallelic_genotype_likelihoods bga_chk u_bga_chk (.*);
